FILE: rtl/sect_pkg.sv
// Package for the sorted event counter table.
// Holds operation and status codes, controller states and the command and status
// structs that join the controller to the datapath. Depends on nothing.
package sect_pkg;

   // Bit width of one stored entry: key, call total and time total.
   localparam int KEY_W   = 32;
   localparam int SUM_W   = 64;
   localparam int ENTRY_W = KEY_W + 2 * SUM_W;

   // Codes of the operation field.
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Codes of the status field of a result.
   typedef enum logic [2:0] {
      ST_INSERTED   = 3'd0,
      ST_UPDATED    = 3'd1,
      ST_OVERFLOW   = 3'd2,
      ST_READ_OK    = 3'd3,
      ST_READ_EMPTY = 3'd4,
      ST_CLEARED    = 3'd5
   } status_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEARCH_ISSUE,
      S_SEARCH_WAIT,
      S_CHECK_WAIT,
      S_MISS,
      S_SHIFT_READ,
      S_SHIFT_WRITE,
      S_INSERT,
      S_READ_WAIT,
      S_FINISH
   } state_type;

   // Datapath actions, one per cycle.
   typedef enum logic [4:0] {
      A_NONE,
      A_LOAD,
      A_SEARCH_ISSUE,
      A_SEARCH_STEP,
      A_CHECK_ISSUE,
      A_HIT_WRITE,
      A_SPILL,
      A_SHIFT_START,
      A_SHIFT_READ,
      A_SHIFT_WRITE,
      A_INSERT,
      A_READ_ISSUE,
      A_READ_CAPTURE,
      A_READ_EMPTY,
      A_CLEAR,
      A_IGNORE,
      A_OUT_LOAD
   } action_type;

   typedef struct packed {
      action_type action;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   search_more;   // search window still open
      logic   in_range;      // search result lies below the entry count
      logic   key_hit;       // entry read back holds the probe key
      logic   full;          // table holds the maximum number of keys
      logic   lo_at_tail;    // insert position is the end of the table
      logic   shift_last;    // current shift source is the insert position
      logic   sel_in_range;  // read slot lies below the entry count
      logic   out_free;      // output register can take a result this cycle
   } stat_type;

endpackage

FILE: rtl/sect_if.sv
// Channel interfaces of the sorted event counter table.
// sect_req_if carries input items, sect_rsp_if carries result items.
// Depends on nothing.
interface sect_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] event_key;
   logic [63:0] call_count;
   logic [63:0] elapsed_ticks;
   logic [5:0]  slot_select;

   modport source (output valid, operation, event_key, call_count, elapsed_ticks,
                   slot_select, input ready);
   modport sink (input valid, operation, event_key, call_count, elapsed_ticks,
                 slot_select, output ready);
endinterface

interface sect_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  slot_index;
   logic [31:0] entry_key;
   logic [63:0] entry_calls;
   logic [63:0] entry_time;
   logic [6:0]  entry_count;
   logic [63:0] spill_calls;
   logic [63:0] spill_time;

   modport source (output valid, status, slot_index, entry_key, entry_calls, entry_time,
                   entry_count, spill_calls, spill_time, input ready);
   modport sink (input valid, status, slot_index, entry_key, entry_calls, entry_time,
                 entry_count, spill_calls, spill_time, output ready);
endinterface

FILE: rtl/sect_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the sorted entry store. Depends on nothing.
module sect_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sect_datapath.sv
// Datapath of the sorted event counter table: item registers, search bounds,
// entry count, spill bucket, entry RAM and output register.
// Depends on sect_pkg, sect_if and sect_ram.
module sect_datapath #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   sect_req_if.sink          req,
   sect_rsp_if.source        rsp,
   input  sect_pkg::cmd_type cmd,
   output sect_pkg::stat_type stat
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int KW    = sect_pkg::KEY_W;
   localparam int SW    = sect_pkg::SUM_W;
   localparam int EW    = sect_pkg::ENTRY_W;

   // Item registers.
   logic [1:0]    op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] calls_ff, calls_in;
   logic [SW-1:0] ticks_ff, ticks_in;
   logic [5:0]    sel_ff, sel_in;

   // Search and shift control.
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] src_ff, src_in;

   // Table state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SW-1:0]    spill_calls_ff, spill_calls_in;
   logic [SW-1:0]    spill_time_ff, spill_time_in;

   // Result of the item in work.
   logic [2:0]    res_status_ff, res_status_in;
   logic [5:0]    res_slot_ff, res_slot_in;
   logic [KW-1:0] res_key_ff, res_key_in;
   logic [SW-1:0] res_calls_ff, res_calls_in;
   logic [SW-1:0] res_time_ff, res_time_in;

   // Output register.
   logic          out_valid_ff, out_valid_in;
   logic [2:0]    out_status_ff, out_status_in;
   logic [5:0]    out_slot_ff, out_slot_in;
   logic [KW-1:0] out_key_ff, out_key_in;
   logic [SW-1:0] out_calls_ff, out_calls_in;
   logic [SW-1:0] out_time_ff, out_time_in;
   logic [6:0]    out_count_ff, out_count_in;
   logic [SW-1:0] out_spill_calls_ff, out_spill_calls_in;
   logic [SW-1:0] out_spill_time_ff, out_spill_time_in;

   // RAM ports.
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [EW-1:0]    wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [EW-1:0]    rd_data;

   logic [KW-1:0]    rd_key;
   logic [SW-1:0]    rd_calls;
   logic [SW-1:0]    rd_time;
   logic [CNT_W-1:0] mid_calc;
   logic [CMP_W-1:0] lo_ext;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] sel_ext;

   sect_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key   = rd_data[EW-1 -: KW];
   assign rd_calls = rd_data[2*SW-1 -: SW];
   assign rd_time  = rd_data[SW-1:0];
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_ext    = CMP_W'(lo_ff);
   assign count_ext = CMP_W'(count_ff);
   assign sel_ext   = CMP_W'(sel_ff);

   always_comb begin
      stat.op           = sect_pkg::op_type'(op_ff);
      stat.search_more  = lo_ff < hi_ff;
      stat.in_range     = lo_ff < count_ff;
      stat.key_hit      = rd_key == key_ff;
      stat.full         = count_ff == CNT_W'(MAX_ENTRIES);
      stat.lo_at_tail   = lo_ff == count_ff;
      stat.shift_last   = CNT_W'(src_ff) == lo_ff;
      stat.sel_in_range = sel_ext < count_ext;
      stat.out_free     = !out_valid_ff || rsp.ready;
   end

   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      calls_in       = calls_ff;
      ticks_in       = ticks_ff;
      sel_in         = sel_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      src_in         = src_ff;
      count_in       = count_ff;
      spill_calls_in = spill_calls_ff;
      spill_time_in  = spill_time_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_key_in     = res_key_ff;
      res_calls_in   = res_calls_ff;
      res_time_in    = res_time_ff;

      out_valid_in       = out_valid_ff && !rsp.ready;
      out_status_in      = out_status_ff;
      out_slot_in        = out_slot_ff;
      out_key_in         = out_key_ff;
      out_calls_in       = out_calls_ff;
      out_time_in        = out_time_ff;
      out_count_in       = out_count_ff;
      out_spill_calls_in = out_spill_calls_ff;
      out_spill_time_in  = out_spill_time_ff;

      wr_en   = 1'b0;
      wr_addr = lo_ff[IDX_W-1:0];
      wr_data = {key_ff, calls_ff, ticks_ff};
      rd_en   = 1'b0;
      rd_addr = lo_ff[IDX_W-1:0];

      unique case (cmd.action)
         sect_pkg::A_NONE: begin
         end
         sect_pkg::A_LOAD: begin
            op_in    = req.operation;
            key_in   = req.event_key;
            calls_in = req.call_count;
            ticks_in = req.elapsed_ticks;
            sel_in   = req.slot_select;
            lo_in    = '0;
            hi_in    = count_ff;
         end
         sect_pkg::A_SEARCH_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = mid_calc[IDX_W-1:0];
            mid_in  = mid_calc[IDX_W-1:0];
         end
         sect_pkg::A_SEARCH_STEP: begin
            if (rd_key < key_ff) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
         end
         sect_pkg::A_CHECK_ISSUE: begin
            rd_en = 1'b1;
         end
         sect_pkg::A_HIT_WRITE: begin
            wr_en         = 1'b1;
            wr_data       = {key_ff, rd_calls + calls_ff, rd_time + ticks_ff};
            res_status_in = sect_pkg::ST_UPDATED;
            res_slot_in   = lo_ext[5:0];
            res_key_in    = key_ff;
            res_calls_in  = rd_calls + calls_ff;
            res_time_in   = rd_time + ticks_ff;
         end
         sect_pkg::A_SPILL: begin
            spill_calls_in = spill_calls_ff + calls_ff;
            spill_time_in  = spill_time_ff + ticks_ff;
            res_status_in  = sect_pkg::ST_OVERFLOW;
            res_slot_in    = '0;
            res_key_in     = '0;
            res_calls_in   = '0;
            res_time_in    = '0;
         end
         sect_pkg::A_SHIFT_START: begin
            src_in = IDX_W'(count_ff - CNT_W'(1));
         end
         sect_pkg::A_SHIFT_READ: begin
            rd_en   = 1'b1;
            rd_addr = src_ff;
         end
         sect_pkg::A_SHIFT_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = src_ff + IDX_W'(1);
            wr_data = rd_data;
            src_in  = src_ff - IDX_W'(1);
         end
         sect_pkg::A_INSERT: begin
            wr_en         = 1'b1;
            count_in      = count_ff + CNT_W'(1);
            res_status_in = sect_pkg::ST_INSERTED;
            res_slot_in   = lo_ext[5:0];
            res_key_in    = key_ff;
            res_calls_in  = calls_ff;
            res_time_in   = ticks_ff;
         end
         sect_pkg::A_READ_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = sel_ext[IDX_W-1:0];
         end
         sect_pkg::A_READ_CAPTURE: begin
            res_status_in = sect_pkg::ST_READ_OK;
            res_slot_in   = sel_ff;
            res_key_in    = rd_key;
            res_calls_in  = rd_calls;
            res_time_in   = rd_time;
         end
         sect_pkg::A_READ_EMPTY: begin
            res_status_in = sect_pkg::ST_READ_EMPTY;
            res_slot_in   = sel_ff;
            res_key_in    = '0;
            res_calls_in  = '0;
            res_time_in   = '0;
         end
         sect_pkg::A_CLEAR: begin
            count_in       = '0;
            spill_calls_in = '0;
            spill_time_in  = '0;
            res_status_in  = sect_pkg::ST_CLEARED;
            res_slot_in    = '0;
            res_key_in     = '0;
            res_calls_in   = '0;
            res_time_in    = '0;
         end
         sect_pkg::A_IGNORE: begin
            res_status_in = sect_pkg::ST_READ_EMPTY;
            res_slot_in   = '0;
            res_key_in    = '0;
            res_calls_in  = '0;
            res_time_in   = '0;
         end
         sect_pkg::A_OUT_LOAD: begin
            out_valid_in       = 1'b1;
            out_status_in      = res_status_ff;
            out_slot_in        = res_slot_ff;
            out_key_in         = res_key_ff;
            out_calls_in       = res_calls_ff;
            out_time_in        = res_time_ff;
            out_count_in       = count_ext[6:0];
            out_spill_calls_in = spill_calls_ff;
            out_spill_time_in  = spill_time_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         spill_calls_ff <= '0;
         spill_time_ff  <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         spill_calls_ff <= spill_calls_in;
         spill_time_ff  <= spill_time_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      key_ff             <= key_in;
      calls_ff           <= calls_in;
      ticks_ff           <= ticks_in;
      sel_ff             <= sel_in;
      lo_ff              <= lo_in;
      hi_ff              <= hi_in;
      mid_ff             <= mid_in;
      src_ff             <= src_in;
      res_status_ff      <= res_status_in;
      res_slot_ff        <= res_slot_in;
      res_key_ff         <= res_key_in;
      res_calls_ff       <= res_calls_in;
      res_time_ff        <= res_time_in;
      out_status_ff      <= out_status_in;
      out_slot_ff        <= out_slot_in;
      out_key_ff         <= out_key_in;
      out_calls_ff       <= out_calls_in;
      out_time_ff        <= out_time_in;
      out_count_ff       <= out_count_in;
      out_spill_calls_ff <= out_spill_calls_in;
      out_spill_time_ff  <= out_spill_time_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.slot_index  = out_slot_ff;
   assign rsp.entry_key   = out_key_ff;
   assign rsp.entry_calls = out_calls_ff;
   assign rsp.entry_time  = out_time_ff;
   assign rsp.entry_count = out_count_ff;
   assign rsp.spill_calls = out_spill_calls_ff;
   assign rsp.spill_time  = out_spill_time_ff;

endmodule

FILE: rtl/sect_controller.sv
// Controller state machine of the sorted event counter table.
// Sequences search, update, shift, insert, read and clear over the datapath.
// Depends on sect_pkg.
module sect_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sect_pkg::stat_type stat,
   output sect_pkg::cmd_type  cmd
);

   sect_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sect_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.action = sect_pkg::A_NONE;
      req_ready  = 1'b0;

      unique case (state_ff)
         sect_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.action = sect_pkg::A_LOAD;
               state_in   = sect_pkg::S_DISPATCH;
            end
         end
         sect_pkg::S_DISPATCH: begin
            case (stat.op)
               sect_pkg::OP_ADD: begin
                  state_in = sect_pkg::S_SEARCH_ISSUE;
               end
               sect_pkg::OP_READ: begin
                  if (stat.sel_in_range) begin
                     cmd.action = sect_pkg::A_READ_ISSUE;
                     state_in   = sect_pkg::S_READ_WAIT;
                  end else begin
                     cmd.action = sect_pkg::A_READ_EMPTY;
                     state_in   = sect_pkg::S_FINISH;
                  end
               end
               sect_pkg::OP_CLEAR: begin
                  cmd.action = sect_pkg::A_CLEAR;
                  state_in   = sect_pkg::S_FINISH;
               end
               default: begin
                  cmd.action = sect_pkg::A_IGNORE;
                  state_in   = sect_pkg::S_FINISH;
               end
            endcase
         end
         sect_pkg::S_SEARCH_ISSUE: begin
            if (stat.search_more) begin
               cmd.action = sect_pkg::A_SEARCH_ISSUE;
               state_in   = sect_pkg::S_SEARCH_WAIT;
            end else if (stat.in_range) begin
               cmd.action = sect_pkg::A_CHECK_ISSUE;
               state_in   = sect_pkg::S_CHECK_WAIT;
            end else begin
               state_in = sect_pkg::S_MISS;
            end
         end
         sect_pkg::S_SEARCH_WAIT: begin
            cmd.action = sect_pkg::A_SEARCH_STEP;
            state_in   = sect_pkg::S_SEARCH_ISSUE;
         end
         sect_pkg::S_CHECK_WAIT: begin
            if (stat.key_hit) begin
               cmd.action = sect_pkg::A_HIT_WRITE;
               state_in   = sect_pkg::S_FINISH;
            end else begin
               state_in = sect_pkg::S_MISS;
            end
         end
         sect_pkg::S_MISS: begin
            if (stat.full) begin
               cmd.action = sect_pkg::A_SPILL;
               state_in   = sect_pkg::S_FINISH;
            end else if (stat.lo_at_tail) begin
               state_in = sect_pkg::S_INSERT;
            end else begin
               cmd.action = sect_pkg::A_SHIFT_START;
               state_in   = sect_pkg::S_SHIFT_READ;
            end
         end
         sect_pkg::S_SHIFT_READ: begin
            cmd.action = sect_pkg::A_SHIFT_READ;
            state_in   = sect_pkg::S_SHIFT_WRITE;
         end
         sect_pkg::S_SHIFT_WRITE: begin
            cmd.action = sect_pkg::A_SHIFT_WRITE;
            state_in   = stat.shift_last ? sect_pkg::S_INSERT : sect_pkg::S_SHIFT_READ;
         end
         sect_pkg::S_INSERT: begin
            cmd.action = sect_pkg::A_INSERT;
            state_in   = sect_pkg::S_FINISH;
         end
         sect_pkg::S_READ_WAIT: begin
            cmd.action = sect_pkg::A_READ_CAPTURE;
            state_in   = sect_pkg::S_FINISH;
         end
         sect_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.action = sect_pkg::A_OUT_LOAD;
               state_in   = sect_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sect_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/sorted_event_counter_table.sv
// Sorted event counter table: one item at a time. An add runs a binary search over
// the n keys held, with one entry RAM read per step, then updates a hit in place,
// spills a miss when the table is full, or else shifts each entry above the insert
// position up one slot, a read and a write per entry, and inserts. A stalled result
// side can hold the next item back from finishing.
// Reset (synchronous, active high) empties the table and zeroes the spill bucket at once.
module sorted_event_counter_table #(
   parameter int MAX_ENTRIES = 64
) (
   input logic        clock,
   input logic        reset,
   sect_req_if.sink   req,
   sect_rsp_if.source rsp
);

   // The controller walks each item through its states and issues one datapath
   // action per cycle. The datapath reports the comparisons the controller needs
   // back through a status struct; nothing else passes between the two.
   sect_pkg::cmd_type  cmd;
   sect_pkg::stat_type stat;
   logic               ready;

   // An input transfer happens only while the controller is idle. The result of
   // the previous item may still sit in the output register at that time, so a
   // stalled result side does not hold off the next item until it has finished.
   assign req.ready = ready;

   sect_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The entries live in RAM in ascending key order. Only slots below the entry
   // count are ever read, and every such slot has been written, so clearing the
   // table only needs the entry count reset.
   sect_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

FILE: rtl/sect_checker.sv
// Port-level checker for the sorted event counter table, with its bind statement.
// Depends on sect_pkg and the top level sorted_event_counter_table.
module sect_checker #(
   parameter int MAX_ENTRIES = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [6:0]  rsp_entry_count,
   input logic [63:0] rsp_spill_calls,
   input logic [63:0] rsp_spill_time
);

   // A pending result stays offered until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid) && !$past(rsp_ready) |-> rsp_valid)
      else $error("result dropped before its transfer");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A clear leaves an empty table and an empty spill bucket.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 3'(sect_pkg::ST_CLEARED)
      |-> rsp_entry_count == 7'd0 && rsp_spill_calls == 64'd0 && rsp_spill_time == 64'd0)
      else $error("clear left entries or spill totals");

   // Overflow happens only with a full table.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 3'(sect_pkg::ST_OVERFLOW)
      |-> rsp_entry_count == 7'(MAX_ENTRIES))
      else $error("overflow reported with room in the table");

endmodule

bind sorted_event_counter_table sect_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_sect_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_entry_count (rsp.entry_count),
   .rsp_spill_calls (rsp.spill_calls),
   .rsp_spill_time  (rsp.spill_time)
);
